// ===== sv/abqc_pkg.sv =====
// Shared types and constants for the alignment block quality check.
// No dependencies; every other file refers to it by scoped name.
package abqc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned RUN_W   = 3;
  localparam int unsigned FLOOR_W = 8;
  localparam int unsigned RATIO_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  // Widest product: 2047 * 15 and 2047 * 10 + 9 both fit in 15 bits.
  localparam int unsigned PROD_W  = 15;

  localparam logic [CHAR_W-1:0] GAP_BYTE = 8'd45;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_RATIO = 2'd2;

  localparam logic [RUN_W-1:0]   RUN_LIMIT_RST      = 3'd4;
  localparam logic [FLOOR_W-1:0] MISMATCH_FLOOR_RST = 8'd3;
  localparam logic [RATIO_W-1:0] MISMATCH_RATIO_RST = 4'd3;

  typedef enum logic [1:0] {
    COL_DEL  = 2'd0,
    COL_INS  = 2'd1,
    COL_ALN  = 2'd2,
    COL_NONE = 2'd3
  } col_type_t;

  // Block totals handed from the counter stage to the verdict stage.
  typedef struct packed {
    logic [COUNT_W-1:0] aligned;
    logic [COUNT_W-1:0] mismatch;
    logic [RUN_W-1:0]   run;
    logic               run_bad;
  } totals_t;

endpackage

// ===== sv/abqc_count.sv =====
// Column classifier and per-block counters (runs, aligned, mismatches).
// Depends on abqc_pkg.
module abqc_count #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [abqc_pkg::CHAR_W-1:0]   read_char,
  input  logic [abqc_pkg::CHAR_W-1:0]   ref_char,
  input  logic                          last_column,
  input  logic [abqc_pkg::RUN_W-1:0]    run_limit,
  output abqc_pkg::totals_t             totals
);

  localparam logic [abqc_pkg::COUNT_W-1:0] COUNT_CAP =
    abqc_pkg::COUNT_W'((MAX_COLUMNS < 2047) ? MAX_COLUMNS : 2047);

  abqc_pkg::col_type_t             prev_type_r, prev_type_nxt, col_type;
  logic [abqc_pkg::RUN_W-1:0]      run_r, run_nxt;
  logic [abqc_pkg::COUNT_W-1:0]    aligned_r, aligned_nxt;
  logic [abqc_pkg::COUNT_W-1:0]    mismatch_r, mismatch_nxt;

  always_comb begin
    if (read_char == abqc_pkg::GAP_BYTE) begin
      col_type = abqc_pkg::COL_DEL;
    end else if (ref_char == abqc_pkg::GAP_BYTE) begin
      col_type = abqc_pkg::COL_INS;
    end else begin
      col_type = abqc_pkg::COL_ALN;
    end

    aligned_nxt  = aligned_r;
    mismatch_nxt = mismatch_r;
    if (col_type == abqc_pkg::COL_ALN) begin
      aligned_nxt = (aligned_r < COUNT_CAP) ? aligned_r + 1'b1 : COUNT_CAP;
      if (read_char != ref_char) begin
        mismatch_nxt = (mismatch_r < COUNT_CAP) ? mismatch_r + 1'b1 : COUNT_CAP;
      end
    end

    // A new run starts whenever the type changes; count saturates at the limit.
    run_nxt       = run_r;
    prev_type_nxt = prev_type_r;
    if (col_type != prev_type_r) begin
      prev_type_nxt = col_type;
      run_nxt = (run_r < run_limit) ? run_r + 1'b1 : run_limit;
    end

    totals.aligned  = aligned_nxt;
    totals.mismatch = mismatch_nxt;
    totals.run      = run_nxt;
    totals.run_bad  = (run_nxt >= run_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_type_r <= abqc_pkg::COL_NONE;
      run_r       <= '0;
      aligned_r   <= '0;
      mismatch_r  <= '0;
    end else if (advance) begin
      if (last_column) begin
        prev_type_r <= abqc_pkg::COL_NONE;
        run_r       <= '0;
        aligned_r   <= '0;
        mismatch_r  <= '0;
      end else begin
        prev_type_r <= prev_type_nxt;
        run_r       <= run_nxt;
        aligned_r   <= aligned_nxt;
        mismatch_r  <= mismatch_nxt;
      end
    end
  end

  a_mismatch_le_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    mismatch_r <= aligned_r)
    else $error("mismatch count exceeds aligned count");

  a_aligned_capped: assert property (@(posedge clk) disable iff (!rst_n)
    aligned_r <= COUNT_CAP)
    else $error("aligned count above cap");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_column |=> run_r == '0 && aligned_r == '0
                               && prev_type_r == abqc_pkg::COL_NONE)
    else $error("counters not cleared after last column");

endmodule

// ===== sv/abqc_verdict.sv =====
// Mismatch-ratio and run-limit test and result register with output handshake.
// Depends on abqc_pkg.
module abqc_verdict (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           snap_valid,
  input  abqc_pkg::totals_t              snap,
  input  logic [abqc_pkg::FLOOR_W-1:0]   mismatch_floor,
  input  logic [abqc_pkg::RATIO_W-1:0]   mismatch_ratio_tenths,
  input  logic                           out_stall,
  output logic                           load_ok,
  output logic                           out_valid,
  output logic                           quality_ok,
  output logic [abqc_pkg::COUNT_W-1:0]   aligned_columns,
  output logic [abqc_pkg::COUNT_W-1:0]   mismatch_total,
  output logic [abqc_pkg::RUN_W-1:0]     run_total
);

  logic                           out_valid_r, out_valid_nxt;
  logic                           quality_ok_r;
  logic [abqc_pkg::COUNT_W-1:0]   aligned_r, mismatch_r;
  logic [abqc_pkg::RUN_W-1:0]     run_r;
  logic [abqc_pkg::PROD_W-1:0]    prod, lim;
  logic                           ratio_bad, bad;

  // m >= floor(a*r/10)  <=>  10*m + 9 >= a*r
  always_comb begin
    prod = abqc_pkg::PROD_W'(snap.aligned) * abqc_pkg::PROD_W'(mismatch_ratio_tenths);
    lim  = abqc_pkg::PROD_W'({snap.mismatch, 3'b000})
         + abqc_pkg::PROD_W'({snap.mismatch, 1'b0})
         + abqc_pkg::PROD_W'(9);
    ratio_bad = (snap.mismatch >= abqc_pkg::COUNT_W'(mismatch_floor)) && (lim >= prod);
    bad       = snap.run_bad || ratio_bad;
  end

  assign load_ok       = !out_valid_r || !out_stall;
  assign out_valid_nxt = load_ok ? snap_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && snap_valid) begin
      quality_ok_r <= !bad;
      aligned_r    <= snap.aligned;
      mismatch_r   <= snap.mismatch;
      run_r        <= snap.run;
    end
  end

  assign out_valid       = out_valid_r;
  assign quality_ok      = quality_ok_r;
  assign aligned_columns = aligned_r;
  assign mismatch_total  = mismatch_r;
  assign run_total       = run_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_ok && snap_valid |=> out_valid_r)
    else $error("result lost on load");

endmodule

// ===== sv/alignment_block_quality_check.sv =====
// Alignment block quality check, top level: input register, counter stage,
// block snapshot register and verdict/result register. Depends on abqc_pkg,
// abqc_count and abqc_verdict.
//
// One alignment column per item enters on in_*; an item is taken on any cycle
// with in_valid high and in_stall low, so a column can follow every cycle. A
// column flows input register -> counter stage -> snapshot register -> result
// register; the result of a block is registered in the snapshot register and
// then the result register, which drives out_*. The counters of the next block
// start on the column right after the last one, so blocks stream without a gap.
// Only a column with last_column set produces an item on out_*. Stalls travel
// back through the stages, each of which can hold one item, so in_stall rises
// only when all three are full. Configuration writes on cfg_* are always taken
// (cfg_ready is tied high) and must only be issued while the block is idle.
// Aligned and mismatch counts saturate at the smaller of MAX_COLUMNS and 2047.
module alignment_block_quality_check #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // column input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [abqc_pkg::CHAR_W-1:0]     in_read_char,
  input  logic [abqc_pkg::CHAR_W-1:0]     in_ref_char,
  input  logic                            in_last_column,
  // verdict output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_quality_ok,
  output logic [abqc_pkg::COUNT_W-1:0]    out_aligned_columns,
  output logic [abqc_pkg::COUNT_W-1:0]    out_mismatch_total,
  output logic [abqc_pkg::RUN_W-1:0]      out_run_total,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abqc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abqc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Config registers
  logic [abqc_pkg::RUN_W-1:0]   run_limit_r;
  logic [abqc_pkg::FLOOR_W-1:0] mismatch_floor_r;
  logic [abqc_pkg::RATIO_W-1:0] mismatch_ratio_r;

  // Input register
  logic                         a_valid_r, a_valid_nxt;
  logic [abqc_pkg::CHAR_W-1:0]  a_read_r, a_ref_r;
  logic                         a_last_r;

  // Snapshot of a finished block
  logic                         b_valid_r, b_valid_nxt;
  abqc_pkg::totals_t            snap_r;
  abqc_pkg::totals_t            totals;

  logic                         c_ready, b_ready, a_ready, a_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r      <= abqc_pkg::RUN_LIMIT_RST;
      mismatch_floor_r <= abqc_pkg::MISMATCH_FLOOR_RST;
      mismatch_ratio_r <= abqc_pkg::MISMATCH_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        abqc_pkg::CFG_RUN_LIMIT:      run_limit_r      <= cfg_data[abqc_pkg::RUN_W-1:0];
        abqc_pkg::CFG_MISMATCH_FLOOR: mismatch_floor_r <= cfg_data;
        abqc_pkg::CFG_MISMATCH_RATIO: mismatch_ratio_r <= cfg_data[abqc_pkg::RATIO_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Backpressure chain: each stage frees up when its successor takes its item.
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign a_fire   = a_valid_r && b_ready;
  assign in_stall = !a_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_ready) begin
      a_valid_nxt = in_valid;
    end
    b_valid_nxt = b_valid_r;
    if (b_ready) begin
      b_valid_nxt = a_fire && a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_read_r <= in_read_char;
      a_ref_r  <= in_ref_char;
      a_last_r <= in_last_column;
    end
    if (a_fire && a_last_r) begin
      snap_r <= totals;
    end
  end

  abqc_count #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (a_fire),
    .read_char   (a_read_r),
    .ref_char    (a_ref_r),
    .last_column (a_last_r),
    .run_limit   (run_limit_r),
    .totals      (totals)
  );

  abqc_verdict u_verdict (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .snap_valid            (b_valid_r),
    .snap                  (snap_r),
    .mismatch_floor        (mismatch_floor_r),
    .mismatch_ratio_tenths (mismatch_ratio_r),
    .out_stall             (out_stall),
    .load_ok               (c_ready),
    .out_valid             (out_valid),
    .quality_ok            (out_quality_ok),
    .aligned_columns       (out_aligned_columns),
    .mismatch_total        (out_mismatch_total),
    .run_total             (out_run_total)
  );

  a_last_reaches_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_last_r |=> b_valid_r)
    else $error("last column did not produce a block snapshot");

  a_snapshot_held: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !c_ready |=> b_valid_r && $stable(snap_r))
    else $error("pending snapshot changed while blocked");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !a_valid_r && !b_valid_r && !out_valid)
    else $error("pipeline not empty after reset");

endmodule
